/* rtl/imap_argument_tokenizer_defines.svh */
// Assertion macros for the argument tokenizer checker
`ifndef IMAP_ARGUMENT_TOKENIZER_DEFINES_SVH
`define IMAP_ARGUMENT_TOKENIZER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define IAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");
// next-cycle implication
`define IAT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");
`endif

/* rtl/iat_pkg.sv */
// Shared types and constants for the IMAP argument tokenizer
`default_nettype none
package iat_pkg;
  localparam int MaxDepth = 16;
  localparam int LitBits = 32;
  localparam int DepthW = 5;
  localparam int LineW = 21;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0, M_CR = 4'd1, M_ATOM = 4'd2, M_STR = 4'd3, M_L8 = 4'd4,
    M_LDIG = 4'd5, M_LCRLF = 4'd6, M_LLF = 4'd7, M_LDATA = 4'd8,
    M_PAUSE = 4'd9, M_DONE = 4'd10
  } mode_t;

  localparam logic [1:0] OP_DATA = 2'd0;
  localparam logic [1:0] OP_LINE = 2'd1;
  localparam logic [1:0] OP_RESUME = 2'd2;

  localparam logic [3:0] EV_ABYTE = 4'd0;
  localparam logic [3:0] EV_AEND = 4'd1;
  localparam logic [3:0] EV_SBYTE = 4'd2;
  localparam logic [3:0] EV_SEND = 4'd3;
  localparam logic [3:0] EV_LSTART = 4'd4;
  localparam logic [3:0] EV_LBYTE = 4'd5;
  localparam logic [3:0] EV_LEND = 4'd6;
  localparam logic [3:0] EV_LOPEN = 4'd7;
  localparam logic [3:0] EV_LCLOSE = 4'd8;
  localparam logic [3:0] EV_EOL = 4'd9;
  localparam logic [3:0] EV_ERR = 4'd10;
  localparam logic [3:0] EV_PAUSE = 4'd11;
  // internal marker for a silent state change, never sent out
  localparam logic [3:0] EV_NONE = 4'd15;

  localparam logic [3:0] ER_PAREN = 4'd1;
  localparam logic [3:0] ER_ATOM = 4'd2;
  localparam logic [3:0] ER_ATOM8 = 4'd3;
  localparam logic [3:0] ER_QUOTE = 4'd4;
  localparam logic [3:0] ER_LOVF = 4'd5;
  localparam logic [3:0] ER_LLINE = 4'd6;
  localparam logic [3:0] ER_PLUS = 4'd7;
  localparam logic [3:0] ER_DIGIT = 4'd8;
  localparam logic [3:0] ER_LLF = 4'd9;
  localparam logic [3:0] ER_CR = 4'd10;
  localparam logic [3:0] ER_CLOSE = 4'd11;
  localparam logic [3:0] ER_L8 = 4'd12;
  localparam logic [3:0] ER_BRACE = 4'd13;
  localparam logic [3:0] ER_LONG = 4'd14;
  localparam logic [3:0] ER_DEEP = 4'd15;

  localparam int CfgW = 20;
  localparam logic [2:0] CFG_MAXLINE = 3'd0;
  localparam logic [2:0] CFG_ALLCH = 3'd1;
  localparam logic [2:0] CFG_INLIST = 3'd2;
  localparam logic [2:0] CFG_MULTI = 3'd3;
  localparam logic [2:0] CFG_KEEPESC = 3'd4;
  localparam logic [2:0] CFG_LIT8 = 3'd5;
  localparam logic [2:0] CFG_SIZEONLY = 3'd6;

  typedef struct packed {
    logic [19:0] max_line;
    logic allchars;
    logic inside_list;
    logic multiline;
    logic keep_esc;
    logic lit8;
    logic size_only;
  } cfg_t;

  // one emitted event
  typedef struct packed {
    logic [3:0] ev;
    logic [7:0] byte_v;
    logic [31:0] lit_len;
    logic [4:0] depth;
    logic nil;
    logic nonsync;
    logic lit8;
    logic cont;
    logic [3:0] err;
    logic fatal;
  } evt_t;

  // up to three events from one byte
  typedef struct packed {
    logic [1:0] n;
    evt_t e0;
    evt_t e1;
    evt_t e2;
  } bundle_t;

  function automatic logic [1:0] atom_bad(input logic [7:0] c);
    if (c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h22 || c == 8'h5C ||
        c <= 8'd32 || c == 8'h7F) return 2'd2;
    if (c[7]) return 2'd3;
    return 2'd0;
  endfunction
endpackage
`default_nettype wire

/* rtl/iat_cfg.sv */
// Configuration register bank
`default_nettype none
module iat_cfg import iat_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            we,
  input  wire logic [2:0]      idx,
  input  wire logic [CfgW-1:0] wdata,
  output cfg_t                 cfg
);
  cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{max_line: 20'd65536, default: 1'b0};
    end else if (we) begin
      unique case (idx)
        CFG_MAXLINE:  cfg_r.max_line <= wdata;
        CFG_ALLCH:    cfg_r.allchars <= wdata[0];
        CFG_INLIST:   cfg_r.inside_list <= wdata[0];
        CFG_MULTI:    cfg_r.multiline <= wdata[0];
        CFG_KEEPESC:  cfg_r.keep_esc <= wdata[0];
        CFG_LIT8:     cfg_r.lit8 <= wdata[0];
        CFG_SIZEONLY: cfg_r.size_only <= wdata[0];
        default: ;
      endcase
    end
  end
  assign cfg = cfg_r;
endmodule
`default_nettype wire

/* rtl/iat_core.sv */
// Per-byte parse state and event generation
`default_nettype none
module iat_core import iat_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       step,
  input  wire logic [1:0] op,
  input  wire logic [7:0] c,
  output bundle_t         bun
);
  mode_t mode_r, mode_nxt;
  logic [DepthW-1:0] depth_r, depth_nxt;
  logic [LitBits-1:0] cnt_r, cnt_nxt, left_r, left_nxt;
  logic [LineW-1:0] lb_r, lb_nxt;
  logic [2:0] nil_r, nil_nxt;
  logic esc_r, esc_nxt, ns_r, ns_nxt, l8_r, l8_nxt, err_r, err_nxt;

  bundle_t b;
  logic [LineW-1:0] lb_inc;
  logic [LitBits+3:0] cnt_x10;
  logic [1:0] bad;
  logic brk;
  logic [20:0] budget;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; depth_r <= '0; cnt_r <= '0; left_r <= '0; lb_r <= '0;
      nil_r <= '0; esc_r <= 1'b0; ns_r <= 1'b0; l8_r <= 1'b0; err_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt; depth_r <= depth_nxt; cnt_r <= cnt_nxt;
      left_r <= left_nxt; lb_r <= lb_nxt; nil_r <= nil_nxt; esc_r <= esc_nxt;
      ns_r <= ns_nxt; l8_r <= l8_nxt; err_r <= err_nxt;
    end
  end

  always_comb begin
    evt_t e;
    mode_t m;
    logic go_idle;
    mode_nxt = mode_r; depth_nxt = depth_r; cnt_nxt = cnt_r; left_nxt = left_r;
    lb_nxt = lb_r; nil_nxt = nil_r; esc_nxt = esc_r; ns_nxt = ns_r;
    l8_nxt = l8_r; err_nxt = err_r;
    b = '0;
    e = '0;
    m = mode_r;
    go_idle = 1'b0;
    lb_inc = (lb_r == {LineW{1'b1}}) ? lb_r : lb_r + LineW'(1);
    cnt_x10 = ({4'b0, cnt_r} << 3) + ({4'b0, cnt_r} << 1) + (LitBits+4)'(c - 8'h30);
    bad = atom_bad(c);
    brk = (c == 8'h0D) || (c == 8'h0A);
    budget = {1'b0, cfg.max_line} - lb_inc;

    if (op == OP_LINE) begin
      mode_nxt = M_IDLE; depth_nxt = '0; cnt_nxt = '0; left_nxt = '0;
      lb_nxt = '0; nil_nxt = '0; esc_nxt = 1'b0; ns_nxt = 1'b0;
      l8_nxt = 1'b0; err_nxt = 1'b0;
    end else if (op == OP_RESUME) begin
      if (!err_r && mode_r == M_PAUSE) begin
        e.ev = EV_LSTART; e.nonsync = ns_r; e.lit8 = l8_r; e.lit_len = cnt_r;
        e.depth = depth_r;
        b.e0 = e; b.n = 2'd1;
        left_nxt = cnt_r;
        if (cnt_r == '0) begin
          e = '0; e.ev = EV_LEND; e.nonsync = ns_r; e.lit8 = l8_r; e.depth = depth_r;
          b.e1 = e; b.n = 2'd2; mode_nxt = M_IDLE;
        end else begin
          mode_nxt = M_LDATA;
        end
      end
    end else if (op == OP_DATA && !err_r && mode_r != M_DONE && mode_r != M_PAUSE) begin
      lb_nxt = lb_inc;
      if (lb_inc > {1'b0, cfg.max_line}) begin
        b.e0 = '{ev: EV_ERR, err: ER_LONG, depth: depth_r, default: '0};
        b.n = 2'd1; err_nxt = 1'b1;
      end else begin
        // atom handling may end the atom and fall through to idle parsing
        if (m == M_ATOM) begin
          if (c == 8'h20 || brk || (c == 8'h29 && (depth_r != '0 || cfg.inside_list))) begin
            b.e0 = '{ev: EV_AEND, nil: (nil_r == 3'd3), depth: depth_r, default: '0};
            b.n = 2'd1; mode_nxt = M_IDLE;
            if (c != 8'h20) begin
              go_idle = 1'b1;
            end
          end else if (c == 8'h29 && !cfg.allchars) begin
            b.e0 = '{ev: EV_ERR, err: ER_PAREN, depth: depth_r, default: '0};
            b.n = 2'd1; err_nxt = 1'b1;
          end else if (c != 8'h29 && bad != 2'd0 && !cfg.allchars) begin
            b.e0 = '{ev: EV_ERR, err: {2'b00, bad}, depth: depth_r, default: '0};
            b.n = 2'd1; err_nxt = 1'b1;
          end else begin
            if (nil_r < 3'd3 && ((nil_r == 3'd0 && c == 8'h4E) ||
                (nil_r == 3'd1 && c == 8'h49) || (nil_r == 3'd2 && c == 8'h4C)))
              nil_nxt = nil_r + 3'd1;
            else nil_nxt = 3'd4;
            b.e0 = '{ev: EV_ABYTE, byte_v: c, depth: depth_r, default: '0};
            b.n = 2'd1;
          end
        end
        if (m == M_IDLE || go_idle) begin
          e = '0; e.depth = depth_r;
          case (c)
            8'h20: ;
            8'h0D: mode_nxt = M_CR;
            8'h0A: begin
              if (cfg.inside_list || depth_r != '0) begin
                e.ev = EV_ERR; e.err = ER_CLOSE; err_nxt = 1'b1;
              end else begin
                e.ev = EV_EOL; mode_nxt = M_DONE;
              end
            end
            8'h22: begin mode_nxt = M_STR; esc_nxt = 1'b0; e.ev = EV_NONE; end
            8'h7E: begin
              if (!cfg.lit8) begin
                e.ev = EV_ERR; e.err = ER_L8; err_nxt = 1'b1;
              end else begin
                mode_nxt = M_L8; cnt_nxt = '0; ns_nxt = 1'b0; l8_nxt = 1'b1; e.ev = EV_NONE;
              end
            end
            8'h7B: begin
              mode_nxt = M_LDIG; cnt_nxt = '0; ns_nxt = 1'b0; l8_nxt = 1'b0; e.ev = EV_NONE;
            end
            8'h28: begin
              if (depth_r >= DepthW'(MaxDepth)) begin
                e.ev = EV_ERR; e.err = ER_DEEP; err_nxt = 1'b1;
              end else begin
                depth_nxt = depth_r + DepthW'(1); e.ev = EV_LOPEN; e.depth = depth_nxt;
              end
            end
            8'h29: begin
              if (depth_r != '0) begin
                depth_nxt = depth_r - DepthW'(1); e.ev = EV_LCLOSE; e.depth = depth_nxt;
              end else if (cfg.inside_list) begin
                e.ev = EV_EOL; mode_nxt = M_DONE;
              end else begin
                e.ev = EV_ERR; e.err = ER_PAREN; err_nxt = 1'b1;
              end
            end
            default: begin
              if (bad != 2'd0 && !cfg.allchars) begin
                e.ev = EV_ERR; e.err = {2'b00, bad}; err_nxt = 1'b1;
              end else begin
                mode_nxt = M_ATOM; nil_nxt = (c == 8'h4E) ? 3'd1 : 3'd4;
                e.ev = EV_ABYTE; e.byte_v = c;
              end
            end
          endcase
          // EV_NONE marks a silent state change; space/CR emit nothing
          if (c != 8'h20 && c != 8'h0D && e.ev != EV_NONE) begin
            if (go_idle) begin b.e1 = e; b.n = 2'd2; end
            else begin b.e0 = e; b.n = 2'd1; end
          end
        end
        case (m)
          M_CR: begin
            if (c == 8'h0A) begin
              if (cfg.inside_list || depth_r != '0) begin
                b.e0 = '{ev: EV_ERR, err: ER_CLOSE, depth: depth_r, default: '0};
                err_nxt = 1'b1; mode_nxt = M_IDLE;
              end else begin
                b.e0 = '{ev: EV_EOL, depth: depth_r, default: '0}; mode_nxt = M_DONE;
              end
            end else begin
              b.e0 = '{ev: EV_ERR, err: ER_CR, depth: depth_r, default: '0}; err_nxt = 1'b1;
            end
            b.n = 2'd1;
          end
          M_STR: begin
            b.n = 2'd1;
            if (esc_r) begin
              esc_nxt = 1'b0;
              if (brk && !cfg.multiline) begin
                b.e0 = '{ev: EV_ERR, err: ER_QUOTE, depth: depth_r, default: '0};
                err_nxt = 1'b1;
              end else b.e0 = '{ev: EV_SBYTE, byte_v: c, depth: depth_r, default: '0};
            end else if (c == 8'h22) begin
              b.e0 = '{ev: EV_SEND, depth: depth_r, default: '0}; mode_nxt = M_IDLE;
            end else if (c == 8'h5C) begin
              esc_nxt = 1'b1;
              b.e0 = '{ev: EV_SBYTE, byte_v: c, depth: depth_r, default: '0};
              if (!cfg.keep_esc) b.n = 2'd0;
            end else if (brk && !cfg.multiline) begin
              b.e0 = '{ev: EV_ERR, err: ER_QUOTE, depth: depth_r, default: '0};
              err_nxt = 1'b1;
            end else b.e0 = '{ev: EV_SBYTE, byte_v: c, depth: depth_r, default: '0};
          end
          M_L8: begin
            if (c == 8'h7B) mode_nxt = M_LDIG;
            else begin
              b.e0 = '{ev: EV_ERR, err: ER_BRACE, depth: depth_r, default: '0};
              b.n = 2'd1; err_nxt = 1'b1;
            end
          end
          M_LDIG: begin
            if (c == 8'h7D) begin
              if (!cfg.size_only) begin
                if (lb_inc >= {1'b0, cfg.max_line} || cnt_r > LitBits'(budget)) begin
                  b.e0 = '{ev: EV_ERR, err: ER_LLINE, fatal: 1'b1, depth: depth_r,
                           default: '0};
                  err_nxt = 1'b1;
                end else begin
                  b.e0 = '{ev: EV_LSTART, lit_len: cnt_r, nonsync: ns_r, lit8: l8_r,
                           cont: !ns_r, depth: depth_r, default: '0};
                  mode_nxt = M_LCRLF;
                end
                b.n = 2'd1;
              end else mode_nxt = M_LCRLF;
            end else if (ns_r) begin
              b.e0 = '{ev: EV_ERR, err: ER_PLUS, depth: depth_r, default: '0};
              b.n = 2'd1; err_nxt = 1'b1;
            end else if (c == 8'h2B) begin
              ns_nxt = 1'b1;
            end else if (c < 8'h30 || c > 8'h39) begin
              b.e0 = '{ev: EV_ERR, err: ER_DIGIT, depth: depth_r, default: '0};
              b.n = 2'd1; err_nxt = 1'b1;
            end else if (cnt_x10[LitBits+3:LitBits] != '0) begin
              b.e0 = '{ev: EV_ERR, err: ER_LOVF, depth: depth_r, default: '0};
              b.n = 2'd1; err_nxt = 1'b1;
            end else cnt_nxt = cnt_x10[LitBits-1:0];
          end
          M_LCRLF, M_LLF: begin
            if (m == M_LCRLF && c == 8'h0D) mode_nxt = M_LLF;
            else if (c == 8'h0A) begin
              b.n = 2'd1;
              if (cfg.size_only) begin
                b.e0 = '{ev: EV_PAUSE, lit_len: cnt_r, nonsync: ns_r, lit8: l8_r,
                         depth: depth_r, default: '0};
                mode_nxt = M_PAUSE;
              end else begin
                left_nxt = cnt_r;
                if (cnt_r == '0) begin
                  b.e0 = '{ev: EV_LEND, nonsync: ns_r, lit8: l8_r, depth: depth_r,
                           default: '0};
                  mode_nxt = M_IDLE;
                end else begin
                  b.n = 2'd0; mode_nxt = M_LDATA;
                end
              end
            end else begin
              b.e0 = '{ev: EV_ERR, err: ER_LLF, depth: depth_r, default: '0};
              b.n = 2'd1; err_nxt = 1'b1;
            end
          end
          M_LDATA: begin
            b.e0 = '{ev: EV_LBYTE, byte_v: c, depth: depth_r, default: '0};
            b.n = 2'd1;
            left_nxt = left_r - LitBits'(1);
            if (left_r == LitBits'(1)) begin
              b.e1 = '{ev: EV_LEND, nonsync: ns_r, lit8: l8_r, depth: depth_r,
                       default: '0};
              b.n = 2'd2; mode_nxt = M_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign bun = b;
endmodule
`default_nettype wire

/* rtl/iat_outq.sv */
// Result buffer: holds up to three events of one byte and drains them in order
`default_nettype none
module iat_outq import iat_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire bundle_t bun,
  output logic         empty_next,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output evt_t         head,
  output logic         head_last
);
  evt_t q_r [3];
  logic [1:0] cnt_r, rd_r;
  logic pop;
  assign pop = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign head = q_r[rd_r];
  assign head_last = (cnt_r == 2'd1);
  // ready for new byte when buffer drains this cycle or is empty
  assign empty_next = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0; rd_r <= 2'd0;
    end else if (load) begin
      cnt_r <= bun.n; rd_r <= 2'd0;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1; rd_r <= rd_r + 2'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (load) begin
      q_r[0] <= bun.e0; q_r[1] <= bun.e1; q_r[2] <= bun.e2;
    end
  end
endmodule
`default_nettype wire

/* rtl/imap_argument_tokenizer.sv */
// Top level of the IMAP command-line argument tokenizer
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata: opcode[1:0], data_byte[9:2]
//  out_    | out | out_tvalid/out_tready| tdata: event fields, tlast: last
//  cfg_    | in  | cfg_we               | cfg_idx selects register, cfg_wdata
//
// One byte is taken per cycle while the result buffer is empty or draining its
// last event; its events (zero to two) are computed in the same cycle and loaded
// into the result buffer. A byte with zero or one event sustains one transfer
// per cycle while out_tready is high; a byte with two events holds the input off as the buffer drains.
// Reset is synchronous, active low; it clears parse state and configuration.
// A stall on the output holds the buffer and, once it is not draining, the input.
`default_nettype none
module imap_argument_tokenizer import iat_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [15:0]     in_tdata,   // opcode[1:0], data_byte[9:2]
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  // event_res[3:0], out_byte[11:4], literal_length[43:12], nest_depth[48:44],
  // is_nil[49], is_nonsync[50], is_literal8[51], continuation_request[52],
  // error_code[56:53], fatal[57]
  output logic [63:0]          out_tdata,
  output logic                 out_tlast,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_idx,
  input  wire logic [CfgW-1:0] cfg_wdata
);
  cfg_t cfg;
  bundle_t bun;
  evt_t head;
  logic empty_next, step;

  iat_cfg u_cfg (.clk, .rst_n, .we(cfg_we), .idx(cfg_idx), .wdata(cfg_wdata), .cfg);

  assign in_tready = empty_next;
  assign step = in_tvalid && in_tready;

  iat_core u_core (.clk, .rst_n, .cfg, .step, .op(in_tdata[1:0]),
                   .c(in_tdata[9:2]), .bun);

  iat_outq u_q (.clk, .rst_n, .load(step), .bun, .empty_next, .out_tvalid,
                .out_tready, .head, .head_last(out_tlast));

  assign out_tdata = {6'd0, head.fatal, head.err, head.cont, head.lit8,
                      head.nonsync, head.nil, head.depth, head.lit_len,
                      head.byte_v, head.ev};
endmodule
`default_nettype wire

/* rtl/iat_checker.sv */
// Port-level checker for the tokenizer, bound to the top level
`include "imap_argument_tokenizer_defines.svh"
`default_nettype none
module iat_checker import iat_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tlast
);
  `IAT_ASSERT_IMP(a_err_code, clk, rst_n, out_tvalid && out_tdata[3:0] != EV_ERR,
    out_tdata[56:53] == 4'd0)
  `IAT_ASSERT_IMP(a_fatal, clk, rst_n, out_tvalid && out_tdata[57],
    out_tdata[56:53] == ER_LLINE)
  `IAT_ASSERT_IMP(a_no_take, clk, rst_n, out_tvalid && !out_tlast, !in_tready)
  `IAT_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule
bind imap_argument_tokenizer iat_checker u_chk (.clk, .rst_n, .in_tready,
  .out_tvalid, .out_tready, .out_tdata, .out_tlast);
`default_nettype wire

/* sim/imap_argument_tokenizer_tb.sv */
// Self-checking testbench for the IMAP argument tokenizer
`default_nettype none
module imap_argument_tokenizer_tb;
  import iat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;
  localparam int LongHold = 300;
  localparam int SettleCycles = 12;

  // one expected event together with its tlast marker (last event of the byte)
  typedef struct {
    evt_t e;
    logic last;
  } token_exp_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [63:0] out_tdata;
  logic out_tlast;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [CfgW-1:0] cfg_wdata;

  imap_argument_tokenizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // stimulus waiting to be driven: opcode in [9:8], byte in [7:0]
  logic [9:0] pending_items[$];
  token_exp_t expected_tokens[$];
  int errors = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;
  bit in_taken = 0;

  // shadow copy of the registers and parse state
  cfg_t cfg;
  mode_t mode;
  int depth;
  logic [63:0] lit_count;
  logic [63:0] lit_left;
  logic [20:0] line_bytes;
  int nil_m;
  bit esc_pend, nsync, lit8_seen, err_latched;
  evt_t step_ev[3];
  int step_n;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Predictor: per-byte token events, at most three per transfer
  // ------------------------------------------------------------------
  function automatic void add_event(logic [3:0] ev, logic [7:0] ch);
    evt_t t;
    t = '0;
    t.ev = ev;
    t.byte_v = ch;
    t.depth = depth[4:0];
    if (ev == EV_LSTART || ev == EV_LEND || ev == EV_PAUSE) begin
      t.nonsync = nsync;
      t.lit8 = lit8_seen;
    end
    if (ev == EV_LSTART || ev == EV_PAUSE) t.lit_len = lit_count[31:0];
    if (step_n >= 3) step_ev[2] = t;
    else begin
      step_ev[step_n] = t;
      step_n++;
    end
  endfunction

  function automatic void flag_error(logic [3:0] code, bit fat);
    add_event(EV_ERR, 8'h00);
    step_ev[step_n-1].err = code;
    step_ev[step_n-1].fatal = fat;
    err_latched = 1;
  endfunction

  function automatic logic [3:0] atom_reject(logic [7:0] c);
    if (c == "(" || c == ")" || c == "{" || c == "\"" || c == "\\" ||
        c <= 8'd32 || c == 8'h7F) return ER_ATOM;
    if (c[7]) return ER_ATOM8;
    return 4'd0;
  endfunction

  function automatic void track_nil(logic [7:0] c);
    if (nil_m == 0 && c == "N") nil_m = 1;
    else if (nil_m == 1 && c == "I") nil_m = 2;
    else if (nil_m == 2 && c == "L") nil_m = 3;
    else nil_m = 4;
  endfunction

  function automatic void close_line();
    if (cfg.inside_list || depth > 0) begin
      flag_error(ER_CLOSE, 0);
      return;
    end
    add_event(EV_EOL, 8'h00);
    mode = M_DONE;
  endfunction

  function automatic void between_args(logic [7:0] c);
    logic [3:0] bad;
    case (c)
      " ": ;
      8'h0D: mode = M_CR;
      8'h0A: close_line();
      "\"": begin
        mode = M_STR;
        esc_pend = 0;
      end
      "~": begin
        if (!cfg.lit8) flag_error(ER_L8, 0);
        else begin
          mode = M_L8;
          lit_count = 0;
          nsync = 0;
          lit8_seen = 1;
        end
      end
      "{": begin
        mode = M_LDIG;
        lit_count = 0;
        nsync = 0;
        lit8_seen = 0;
      end
      "(": begin
        if (depth >= MaxDepth) flag_error(ER_DEEP, 0);
        else begin
          depth++;
          add_event(EV_LOPEN, 8'h00);
        end
      end
      ")": begin
        if (depth > 0) begin
          depth--;
          add_event(EV_LCLOSE, 8'h00);
        end else if (cfg.inside_list) begin
          add_event(EV_EOL, 8'h00);
          mode = M_DONE;
        end else flag_error(ER_PAREN, 0);
      end
      default: begin
        bad = atom_reject(c);
        if (bad != 0 && !cfg.allchars) flag_error(bad, 0);
        else begin
          mode = M_ATOM;
          nil_m = 0;
          track_nil(c);
          add_event(EV_ABYTE, c);
        end
      end
    endcase
  endfunction

  function automatic void finish_atom();
    add_event(EV_AEND, 8'h00);
    step_ev[step_n-1].nil = (nil_m == 3);
    mode = M_IDLE;
  endfunction

  function automatic void in_atom(logic [7:0] c);
    logic [3:0] bad;
    if (c == " ") begin
      finish_atom();
      return;
    end
    if (c == 8'h0D || c == 8'h0A) begin
      finish_atom();
      between_args(c);
      return;
    end
    if (c == ")") begin
      if (depth > 0 || cfg.inside_list) begin
        finish_atom();
        between_args(c);
        return;
      end
      if (!cfg.allchars) begin
        flag_error(ER_PAREN, 0);
        return;
      end
    end else begin
      bad = atom_reject(c);
      if (bad != 0 && !cfg.allchars) begin
        flag_error(bad, 0);
        return;
      end
    end
    track_nil(c);
    add_event(EV_ABYTE, c);
  endfunction

  function automatic void in_string(logic [7:0] c);
    bit brk;
    brk = (c == 8'h0D || c == 8'h0A);
    if (esc_pend) begin
      esc_pend = 0;
      if (brk && !cfg.multiline) flag_error(ER_QUOTE, 0);
      else add_event(EV_SBYTE, c);
    end else if (c == "\"") begin
      add_event(EV_SEND, 8'h00);
      mode = M_IDLE;
    end else if (c == "\\") begin
      esc_pend = 1;
      if (cfg.keep_esc) add_event(EV_SBYTE, c);
    end else if (brk && !cfg.multiline) flag_error(ER_QUOTE, 0);
    else add_event(EV_SBYTE, c);
  endfunction

  function automatic void in_size(logic [7:0] c);
    logic [63:0] d;
    if (c == "}") begin
      if (!cfg.size_only) begin
        if ({43'd0, line_bytes} >= {44'd0, cfg.max_line} ||
            lit_count > ({44'd0, cfg.max_line} - {43'd0, line_bytes})) begin
          flag_error(ER_LLINE, 1);
          return;
        end
        add_event(EV_LSTART, 8'h00);
        step_ev[step_n-1].cont = !nsync;
      end
      mode = M_LCRLF;
      return;
    end
    if (nsync) begin
      flag_error(ER_PLUS, 0);
      return;
    end
    if (c == "+") begin
      nsync = 1;
      return;
    end
    if (c < "0" || c > "9") begin
      flag_error(ER_DIGIT, 0);
      return;
    end
    d = 64'(c - "0");
    if (lit_count > (64'hFFFF_FFFF - d) / 10) begin
      flag_error(ER_LOVF, 0);
      return;
    end
    lit_count = lit_count * 10 + d;
  endfunction

  function automatic void open_data();
    lit_left = lit_count;
    if (lit_left == 0) begin
      add_event(EV_LEND, 8'h00);
      mode = M_IDLE;
    end else mode = M_LDATA;
  endfunction

  function automatic void after_header();
    if (cfg.size_only) begin
      add_event(EV_PAUSE, 8'h00);
      mode = M_PAUSE;
    end else open_data();
  endfunction

  function automatic void line_clear();
    mode = M_IDLE;
    depth = 0;
    lit_count = 0;
    lit_left = 0;
    line_bytes = 0;
    nil_m = 0;
    esc_pend = 0;
    nsync = 0;
    lit8_seen = 0;
    err_latched = 0;
  endfunction

  // work out the events of one accepted transfer and queue them
  function automatic void tokenize_step(logic [1:0] op, logic [7:0] c);
    token_exp_t x;
    step_n = 0;
    if (op == OP_LINE) line_clear();
    else if (op == OP_RESUME) begin
      if (!err_latched && mode == M_PAUSE) begin
        add_event(EV_LSTART, 8'h00);
        open_data();
      end
    end else if (op == OP_DATA && !err_latched && mode != M_DONE && mode != M_PAUSE) begin
      if (line_bytes < 21'h1FFFFF) line_bytes++;
      if ({11'd0, line_bytes} > {12'd0, cfg.max_line}) flag_error(ER_LONG, 0);
      else begin
        case (mode)
          M_IDLE: between_args(c);
          M_CR: begin
            if (c == 8'h0A) begin
              mode = M_IDLE;
              close_line();
            end else flag_error(ER_CR, 0);
          end
          M_ATOM: in_atom(c);
          M_STR: in_string(c);
          M_L8: begin
            if (c == "{") mode = M_LDIG;
            else flag_error(ER_BRACE, 0);
          end
          M_LDIG: in_size(c);
          M_LCRLF: begin
            if (c == 8'h0D) mode = M_LLF;
            else if (c == 8'h0A) after_header();
            else flag_error(ER_LLF, 0);
          end
          M_LLF: begin
            if (c == 8'h0A) after_header();
            else flag_error(ER_LLF, 0);
          end
          M_LDATA: begin
            add_event(EV_LBYTE, c);
            lit_left--;
            if (lit_left == 0) begin
              add_event(EV_LEND, 8'h00);
              mode = M_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
    for (int k = 0; k < step_n; k++) begin
      x.e = step_ev[k];
      x.last = (k == step_n - 1);
      expected_tokens.push_back(x);
    end
  endfunction

  // ------------------------------------------------------------------
  // Driver: bursts of transfers separated by random gaps
  // ------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    logic nv;
    logic [15:0] nd;
    logic [9:0] item;
    nv = in_tvalid && !in_taken;
    nd = in_tdata;
    in_taken = 0;
    if (rst_n && !nv) begin
      if (gap_left > 0) gap_left--;
      else if (pending_items.size() > 0) begin
        item = pending_items.pop_front();
        nd = {6'd0, item[7:0], item[9:8]};
        nv = 1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(30);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end
      end
    end
    in_tvalid <= nv;
    in_tdata <= nd;
  end

  // ------------------------------------------------------------------
  // Receiver: its own stall pattern, plus one long hold-off
  // ------------------------------------------------------------------
  int stall_phase = 0;
  always @(negedge clk) begin
    logic rdy;
    stall_phase++;
    if (hold_cycles > 0) begin
      hold_cycles--;
      rdy = 0;
    end else if ((stall_phase % 64) < 24) rdy = 1;
    else rdy = ($urandom_range(3) != 0);
    out_tready <= rdy;
  end

  // ------------------------------------------------------------------
  // Monitor and scoreboard
  // ------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    token_exp_t x;
    if (rst_n && in_tvalid && in_tready) begin
      in_taken = 1;
      tokenize_step(in_tdata[1:0], in_tdata[9:2]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0)
        report_mismatch("unexpected event", out_tdata[3:0], 0);
      else begin
        x = expected_tokens.pop_front();
        if (out_tdata[3:0] != x.e.ev) report_mismatch("event_res", out_tdata[3:0], x.e.ev);
        if (out_tdata[11:4] != x.e.byte_v)
          report_mismatch("out_byte", out_tdata[11:4], x.e.byte_v);
        if (out_tdata[43:12] != x.e.lit_len)
          report_mismatch("literal_length", out_tdata[43:12], x.e.lit_len);
        if (out_tdata[48:44] != x.e.depth)
          report_mismatch("nest_depth", out_tdata[48:44], x.e.depth);
        if (out_tdata[49] != x.e.nil) report_mismatch("is_nil", out_tdata[49], x.e.nil);
        if (out_tdata[50] != x.e.nonsync)
          report_mismatch("is_nonsync", out_tdata[50], x.e.nonsync);
        if (out_tdata[51] != x.e.lit8)
          report_mismatch("is_literal8", out_tdata[51], x.e.lit8);
        if (out_tdata[52] != x.e.cont)
          report_mismatch("continuation_request", out_tdata[52], x.e.cont);
        if (out_tdata[56:53] != x.e.err)
          report_mismatch("error_code", out_tdata[56:53], x.e.err);
        if (out_tdata[57] != x.e.fatal) report_mismatch("fatal", out_tdata[57], x.e.fatal);
        if (out_tlast !== x.last) report_mismatch("tlast", out_tlast, x.last);
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("imap_argument_tokenizer regression: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  function automatic void queue_item(logic [1:0] op, logic [7:0] c);
    pending_items.push_back({op, c});
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_item(OP_DATA, s[i]);
  endfunction

  // one command line with random, possibly malformed, content
  function automatic void queue_line();
    int open_lists, ntok, n;
    string digits;
    open_lists = 0;
    queue_item(OP_LINE, 8'($urandom_range(255)));
    ntok = $urandom_range(1, 6);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) queue_text(" ");
      case ($urandom_range(6))
        0: queue_text("NIL");
        1, 2: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) queue_item(OP_DATA, 8'($urandom_range(33, 126)));
        end
        3: begin
          queue_text("\"");
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++)
            if ($urandom_range(4) == 0) queue_text("\\\"");
            else queue_item(OP_DATA, 8'($urandom_range(32, 255)));
          queue_text("\"");
        end
        4: begin
          n = $urandom_range(0, 4);
          if (cfg.lit8 && $urandom_range(1)) queue_text("~");
          digits.itoa(n);
          queue_text({"{", digits});
          if ($urandom_range(1) == 1) queue_text("+");
          queue_text("}\r\n");
          if (cfg.size_only) queue_item(OP_RESUME, 8'($urandom_range(255)));
          for (int i = 0; i < n; i++) queue_item(OP_DATA, 8'($urandom_range(255)));
        end
        5: begin
          queue_text("(");
          open_lists++;
        end
        default: begin
          if (open_lists > 0) begin
            queue_text(")");
            open_lists--;
          end else queue_text("A");
        end
      endcase
    end
    while (open_lists > 0) begin
      queue_text(")");
      open_lists--;
    end
    queue_text($urandom_range(1) ? "\r\n" : "\n");
  endfunction

  function automatic void queue_noise();
    queue_item(2'($urandom_range(3)), 8'($urandom_range(255)));
  endfunction

  task automatic wait_quiet();
    while (pending_items.size() > 0 || in_tvalid || expected_tokens.size() > 0)
      @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_MAXLINE: cfg.max_line = val;
      CFG_ALLCH: cfg.allchars = val[0];
      CFG_INLIST: cfg.inside_list = val[0];
      CFG_MULTI: cfg.multiline = val[0];
      CFG_KEEPESC: cfg.keep_esc = val[0];
      CFG_LIT8: cfg.lit8 = val[0];
      CFG_SIZEONLY: cfg.size_only = val[0];
      default: ;
    endcase
  endtask

  task automatic random_phase(int items, int noise_pct);
    int start;
    start = pending_items.size();
    while (pending_items.size() - start < items)
      if ($urandom_range(99) < noise_pct) queue_noise();
      else queue_line();
  endtask

  task automatic set_all(logic [19:0] ml, bit ac, bit il, bit mu, bit ke, bit l8, bit so);
    wait_quiet();
    write_reg(CFG_MAXLINE, ml);
    write_reg(CFG_ALLCH, CfgW'(ac));
    write_reg(CFG_INLIST, CfgW'(il));
    write_reg(CFG_MULTI, CfgW'(mu));
    write_reg(CFG_KEEPESC, CfgW'(ke));
    write_reg(CFG_LIT8, CfgW'(l8));
    write_reg(CFG_SIZEONLY, CfgW'(so));
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    cfg_we = 0;
    cfg_idx = CFG_MAXLINE;
    cfg_wdata = '0;
    cfg = '0;
    cfg.max_line = 20'd65536;
    line_clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: NIL, atom errors, list close at depth zero, strings, literal faults
    queue_item(OP_LINE, 0); queue_text("NIL nil ( ) \"a\\\"b\" {0}\r\n\r\n");
    queue_item(OP_LINE, 0); queue_text(")");
    queue_item(OP_LINE, 0); queue_text("a\x80");
    queue_item(OP_LINE, 0); queue_text("a{");
    queue_item(OP_LINE, 0); queue_text("ab)");
    queue_item(OP_LINE, 0); queue_text("\"x\ny\"");
    queue_item(OP_LINE, 0); queue_text("\"x\\\ry\"");
    queue_item(OP_LINE, 0); queue_text("\rX");
    queue_item(OP_LINE, 0); queue_text("{99999999999}");
    queue_item(OP_LINE, 0); queue_text("{1+2}");
    queue_item(OP_LINE, 0); queue_text("{1x}");
    queue_item(OP_LINE, 0); queue_text("{70000}\r\n");
    queue_item(OP_LINE, 0); queue_text("{2}\rX");
    queue_item(OP_LINE, 0); queue_text("~{1}");
    queue_item(OP_LINE, 0); queue_text("(a\n");
    queue_item(OP_LINE, 0); queue_text("(((((((((((((((((");
    queue_item(OP_LINE, 0); queue_item(OP_RESUME, 8'hFF); queue_item(2'd3, 8'h00);
    queue_text("\n x");
    random_phase(6, 10);

    // widest settings, every relaxation on; hold the receiver off to back up the block
    set_all(20'hFFFFF, 1, 0, 1, 1, 1, 0);
    queue_item(OP_LINE, 0); queue_text("a)\x80 ~x \"p\\\nq\" ~{3+}\r\nxyz\r\n");
    hold_cycles = LongHold;
    random_phase(6, 10);

    // short lines, already inside a list, sizes reported and paused
    set_all(20'd40, 0, 1, 0, 0, 1, 1);
    queue_item(OP_LINE, 0); queue_text("a) ");
    queue_item(OP_LINE, 0); queue_text("{5}\r\nzz"); queue_item(OP_RESUME, 0);
    queue_text("12345)");
    random_phase(6, 15);

    // zero line budget: the first data byte of every line is too long
    set_all(20'd0, 0, 0, 0, 0, 0, 0);
    random_phase(4, 20);

    // back to a modest budget so literals can exceed it
    set_all(20'd12, 0, 0, 0, 0, 1, 0);
    random_phase(6, 10);

    wait_quiet();
    if (errors == 0) $display("imap_argument_tokenizer regression: pass");
    else $display("imap_argument_tokenizer regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
